// ===== hw/rtl/fau_pkg.sv =====
package fau_pkg;

	localparam int CMD_W  = 3;
	localparam int RES_W  = 33;
	localparam int OUT_TW = 72;

	localparam logic [CMD_W-1:0] CMD_REDUCE = 3'd0;
	localparam logic [CMD_W-1:0] CMD_ADD    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_SUB    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_MUL    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DIV    = 3'd4;

	typedef struct packed {
		logic start;
	} unit_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

endpackage

// ===== hw/rtl/fau_gcd.sv =====
module fau_gcd #(
	parameter int PW = 34
) (
	input  logic              clk,
	input  logic              arst_n,
	input  fau_pkg::unit_ctl_t ctl,
	input  logic [PW-1:0]     x,
	input  logic [PW-1:0]     y,
	output fau_pkg::unit_sts_t sts,
	output logic [PW-1:0]     g
);
	import fau_pkg::*;

	localparam int KW = $clog2(PW + 1);

	logic [PW-1:0] x_q;
	logic [PW-1:0] y_q;
	logic [PW-1:0] g_q;
	logic [KW-1:0] k_q;
	logic          busy_q;
	logic          done_q;
	logic          fin;

	assign fin = (x_q == '0) || (y_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && fin && !ctl.start;
			if (ctl.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && fin) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Binary gcd: common factors of two are counted in k_q and restored at the end.
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			x_q <= x;
			y_q <= y;
			k_q <= '0;
		end else if (busy_q) begin
			if (fin) begin
				g_q <= (x_q | y_q) << k_q;
			end else if (!x_q[0] && !y_q[0]) begin
				x_q <= x_q >> 1;
				y_q <= y_q >> 1;
				k_q <= KW'(k_q + 1'b1);
			end else if (!x_q[0]) begin
				x_q <= x_q >> 1;
			end else if (!y_q[0]) begin
				y_q <= y_q >> 1;
			end else if (x_q >= y_q) begin
				x_q <= (x_q - y_q) >> 1;
			end else begin
				y_q <= (y_q - x_q) >> 1;
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign g        = g_q;

endmodule

// ===== hw/rtl/fau_div.sv =====
module fau_div #(
	parameter int PW = 34
) (
	input  logic              clk,
	input  logic              arst_n,
	input  fau_pkg::unit_ctl_t ctl,
	input  logic [PW-1:0]     dividend,
	input  logic [PW-1:0]     divisor,
	output fau_pkg::unit_sts_t sts,
	output logic [PW-1:0]     quo
);
	import fau_pkg::*;

	localparam int CW = $clog2(PW);

	logic [PW:0]   rem_q;
	logic [PW-1:0] quo_q;
	logic [PW-1:0] div_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [PW:0]   trial;
	logic [PW:0]   diff;
	logic          ge;

	assign trial = {rem_q[PW-1:0], quo_q[PW-1]};
	assign diff  = trial - {1'b0, div_q};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == '0) && !ctl.start;
			if (ctl.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && (cnt_q == '0)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Restoring division, one quotient bit per cycle.
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
			cnt_q <= CW'(PW - 1);
		end else if (busy_q) begin
			rem_q <= ge ? diff : trial;
			quo_q <= {quo_q[PW-2:0], ge};
			cnt_q <= CW'(cnt_q - 1'b1);
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quo      = quo_q;

endmodule

// ===== hw/rtl/fraction_arithmetic_unit.sv =====
// Fraction arithmetic unit.
// Input channel s_axis: tuser carries the operation (reduce a, add, subtract, multiply,
// divide; unused codes reduce a), tdata carries a_num, a_den, b_num, b_den, each
// OPERAND_WIDTH bits in two's complement. One transfer is one operation.
// Output channel m_axis: tdata carries the reduced numerator and denominator, 33 bits
// each, with the sign on the numerator unless a zero part is passed through unchanged.
// Work runs on one shared multiplier, then a binary gcd unit, then one bit-serial divider
// that is used for the numerator and then the denominator.
// The steps run in order: the multiply states S_MUL0, S_MUL1 and S_MUL2, a sign step,
// the gcd and the two divisions. A result with a zero part skips the gcd and the
// divisions and goes from the sign step straight to write-back.
// Only one operation is in flight; s_axis_tready is high only while the unit is idle.
// The result sits in an output register, so a new operation is taken while an old
// result waits; a stalled receiver holds the finished next result until the register
// frees. Reset clears the sequencer and the output valid; no result is pending then.
module fraction_arithmetic_unit #(
	parameter int OPERAND_WIDTH = 16
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     s_axis_tvalid,
	output logic                                     s_axis_tready,
	// a_num, a_den, b_num, b_den from the lowest bit up, zero padded to bytes.
	input  logic [((4*OPERAND_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
	// cmd.
	input  logic [fau_pkg::CMD_W-1:0]                s_axis_tuser,
	output logic                                     m_axis_tvalid,
	input  logic                                     m_axis_tready,
	// res_num, res_den from the lowest bit up, zero padded to bytes.
	output logic [fau_pkg::OUT_TW-1:0]               m_axis_tdata
);
	import fau_pkg::*;

	localparam int W  = OPERAND_WIDTH;
	localparam int MW = W + 1;
	localparam int PW = 2 * W + 2;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_MUL0   = 4'd1;
	localparam logic [3:0] S_MUL1   = 4'd2;
	localparam logic [3:0] S_MUL2   = 4'd3;
	localparam logic [3:0] S_SIGN   = 4'd4;
	localparam logic [3:0] S_GSTART = 4'd5;
	localparam logic [3:0] S_GWAIT  = 4'd6;
	localparam logic [3:0] S_NSTART = 4'd7;
	localparam logic [3:0] S_NWAIT  = 4'd8;
	localparam logic [3:0] S_DSTART = 4'd9;
	localparam logic [3:0] S_DWAIT  = 4'd10;
	localparam logic [3:0] S_WB     = 4'd11;

	logic [3:0]            state_q;
	logic [CMD_W-1:0]      cmd_q;
	logic signed [W-1:0]   an_q;
	logic signed [W-1:0]   ad_q;
	logic signed [W-1:0]   bn_q;
	logic signed [W-1:0]   bd_q;
	logic signed [PW-1:0]  prod_q;
	logic signed [PW-1:0]  num_q;
	logic signed [PW-1:0]  den_q;
	logic [PW-1:0]         g_q;
	logic signed [RES_W-1:0] res_num_q;
	logic signed [RES_W-1:0] res_den_q;
	logic [RES_W-1:0]      out_num_q;
	logic [RES_W-1:0]      out_den_q;
	logic                  m_valid_q;

	logic signed [MW-1:0]  an_x;
	logic signed [MW-1:0]  ad_x;
	logic signed [MW-1:0]  bn_x;
	logic signed [MW-1:0]  bd_x;
	logic signed [MW-1:0]  ad_abs;
	logic signed [MW-1:0]  bd_abs;
	logic signed [MW-1:0]  one_x;
	logic signed [MW-1:0]  y0;
	logic signed [MW-1:0]  y2;
	logic signed [MW-1:0]  mul_x;
	logic signed [MW-1:0]  mul_y;
	logic signed [PW-1:0]  mul_p;
	logic                  is_add;
	logic                  is_sub;
	logic [PW-1:0]         num_mag;
	logic                  out_free;

	unit_ctl_t             gcd_ctl;
	unit_sts_t             gcd_sts;
	logic [PW-1:0]         gcd_g;
	unit_ctl_t             div_ctl;
	unit_sts_t             div_sts;
	logic [PW-1:0]         div_in;
	logic [PW-1:0]         div_quo;

	assign an_x   = MW'(an_q);
	assign ad_x   = MW'(ad_q);
	assign bn_x   = MW'(bn_q);
	assign bd_x   = MW'(bd_q);
	assign ad_abs = ad_x[MW-1] ? -ad_x : ad_x;
	assign bd_abs = bd_x[MW-1] ? -bd_x : bd_x;
	assign one_x  = {{(MW-1){1'b0}}, 1'b1};
	assign is_add = cmd_q == CMD_ADD;
	assign is_sub = cmd_q == CMD_SUB;

	// Reduce runs as a_num*1 over a_den*1 so every operation uses the same three products.
	always_comb begin
		unique case (cmd_q)
			CMD_ADD, CMD_SUB: begin
				y0 = bd_abs;
				y2 = bd_abs;
			end
			CMD_MUL: begin
				y0 = bn_x;
				y2 = bd_x;
			end
			CMD_DIV: begin
				y0 = bd_x;
				y2 = bn_x;
			end
			CMD_REDUCE: begin
				y0 = one_x;
				y2 = one_x;
			end
			default: begin
				y0 = one_x;
				y2 = one_x;
			end
		endcase
	end

	always_comb begin
		unique case (state_q)
			S_MUL0: begin
				mul_x = an_x;
				mul_y = y0;
			end
			S_MUL1: begin
				mul_x = bn_x;
				mul_y = ad_abs;
			end
			default: begin
				mul_x = ad_x;
				mul_y = y2;
			end
		endcase
	end

	assign mul_p    = PW'(mul_x) * PW'(mul_y);
	assign num_mag  = num_q[PW-1] ? PW'(-num_q) : PW'(num_q);
	assign out_free = !m_valid_q || m_axis_tready;

	assign gcd_ctl.start = state_q == S_GSTART;
	assign div_ctl.start = (state_q == S_NSTART) || (state_q == S_DSTART);
	assign div_in        = (state_q == S_NSTART) ? num_mag : PW'(den_q);

	fau_gcd #(
		.PW(PW)
	) u_gcd (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (gcd_ctl),
		.x     (num_mag),
		.y     (PW'(den_q)),
		.sts   (gcd_sts),
		.g     (gcd_g)
	);

	fau_div #(
		.PW(PW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (div_ctl),
		.dividend(div_in),
		.divisor (g_q),
		.sts     (div_sts),
		.quo     (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_WB) && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= S_MUL0;
					end
				end
				S_MUL0: state_q <= S_MUL1;
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_SIGN;
				S_SIGN: begin
					if ((num_q == '0) || (prod_q == '0)) begin
						state_q <= S_WB;
					end else begin
						state_q <= S_GSTART;
					end
				end
				S_GSTART: state_q <= S_GWAIT;
				S_GWAIT: begin
					if (gcd_sts.done) begin
						state_q <= S_NSTART;
					end
				end
				S_NSTART: state_q <= S_NWAIT;
				S_NWAIT: begin
					if (div_sts.done) begin
						state_q <= S_DSTART;
					end
				end
				S_DSTART: state_q <= S_DWAIT;
				S_DWAIT: begin
					if (div_sts.done) begin
						state_q <= S_WB;
					end
				end
				S_WB: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) begin
					cmd_q <= s_axis_tuser;
					an_q  <= s_axis_tdata[W-1:0];
					ad_q  <= s_axis_tdata[2*W-1:W];
					bn_q  <= s_axis_tdata[3*W-1:2*W];
					bd_q  <= s_axis_tdata[4*W-1:3*W];
				end
			end
			S_MUL0: prod_q <= mul_p;
			S_MUL1: begin
				num_q  <= prod_q;
				prod_q <= mul_p;
			end
			S_MUL2: begin
				if (is_add) begin
					num_q <= num_q + prod_q;
				end else if (is_sub) begin
					num_q <= num_q - prod_q;
				end
				prod_q <= mul_p;
			end
			S_SIGN: begin
				res_num_q <= RES_W'(num_q);
				res_den_q <= RES_W'(prod_q);
				if (prod_q[PW-1]) begin
					num_q <= -num_q;
					den_q <= -prod_q;
				end else begin
					den_q <= prod_q;
				end
			end
			S_GWAIT: begin
				if (gcd_sts.done) begin
					g_q <= gcd_g;
				end
			end
			S_NWAIT: begin
				if (div_sts.done) begin
					res_num_q <= num_q[PW-1] ? RES_W'(-signed'(div_quo)) :
						RES_W'(signed'(div_quo));
				end
			end
			S_DWAIT: begin
				if (div_sts.done) begin
					res_den_q <= RES_W'(signed'(div_quo));
				end
			end
			S_WB: begin
				if (out_free) begin
					out_num_q <= res_num_q;
					out_den_q <= res_den_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign s_axis_tready = state_q == S_IDLE;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{(OUT_TW-2*RES_W){1'b0}}, out_den_q, out_num_q};

	a_gcd_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		gcd_sts.done |-> state_q == S_GWAIT)
		else $error("gcd result outside of its wait state");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.done |-> (state_q == S_NWAIT) || (state_q == S_DWAIT))
		else $error("divider result outside of its wait states");

	a_gcd_started: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_GSTART |=> gcd_sts.busy)
		else $error("gcd unit did not start");

	a_gcd_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		gcd_sts.done |-> gcd_g != '0)
		else $error("gcd of nonzero parts came out zero");

	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DWAIT) && div_sts.done |-> div_quo != '0)
		else $error("reduced denominator came out zero");

	a_wb_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WB) && m_axis_tvalid && !m_axis_tready |=> state_q == S_WB)
		else $error("result overwrote an output transfer still pending");

endmodule
